/* hdl/fctm_pkg.sv */
// Shared types and constants for the front-coded term matcher.
package fctm_pkg;

   localparam int BYTE_W        = 8;
   localparam int REQ_TYPE_W    = 2;
   localparam int TERM_TOTAL_W  = 13;
   localparam int INDEX_W       = 12;
   localparam int TERM_LEN_W    = 9;
   localparam int PHASE_W       = 2;
   localparam int MAX_BLOCK_TERMS = 4096;

   // Request codes as they arrive on the input channel.
   localparam logic [REQ_TYPE_W-1:0] OP_CLEAR  = 2'd0;
   localparam logic [REQ_TYPE_W-1:0] OP_APPEND = 2'd1;
   localparam logic [REQ_TYPE_W-1:0] OP_START  = 2'd2;
   localparam logic [REQ_TYPE_W-1:0] OP_BYTE   = 2'd3;

   // Parse phases of the block scanner.
   localparam logic [PHASE_W-1:0] PH_IDLE   = 2'd0;
   localparam logic [PHASE_W-1:0] PH_PREFIX = 2'd1;
   localparam logic [PHASE_W-1:0] PH_SUFLEN = 2'd2;
   localparam logic [PHASE_W-1:0] PH_BYTES  = 2'd3;

   // One classified request as it travels from the front to the back.
   typedef struct packed {
      logic [REQ_TYPE_W-1:0]   op;
      logic [BYTE_W-1:0]       data;
      logic [TERM_TOTAL_W-1:0] total;
      logic                    total_zero;
   } item_type;

endpackage

/* hdl/fctm_if.sv */
// Valid/ready channel interfaces for requests and responses.
interface fctm_req_if;
   logic                                valid;
   logic                                ready;
   logic [fctm_pkg::REQ_TYPE_W-1:0]     req_type;
   logic [fctm_pkg::BYTE_W-1:0]         data_byte;
   logic [fctm_pkg::TERM_TOTAL_W-1:0]   term_total;

   modport source (output valid, output req_type, output data_byte, output term_total,
                   input ready);
   modport sink (input valid, input req_type, input data_byte, input term_total,
                 output ready);
endinterface

interface fctm_rsp_if;
   logic                           valid;
   logic                           ready;
   logic                           found;
   logic [fctm_pkg::INDEX_W-1:0]   match_index;

   modport source (output valid, output found, output match_index, input ready);
   modport sink (input valid, input found, input match_index, output ready);
endinterface

/* hdl/fctm_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read data.
module fctm_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 255
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

/* hdl/fctm_front.sv */
// Request front end: classifies incoming transactions into a two-entry queue.
module fctm_front (
   input  logic                clock,
   input  logic                reset,
   fctm_req_if.sink            req_bus,
   output logic                q_valid,
   output fctm_pkg::item_type  q_item,
   input  logic                q_pop
);

   localparam int QDEPTH = 2;

   fctm_pkg::item_type entry_ff [QDEPTH];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       push;
   fctm_pkg::item_type new_item;
   logic [16:0] total_wide;

   assign req_bus.ready = (count_ff != 2'(QDEPTH));
   assign push = req_bus.valid && req_bus.ready;

   // Saturate the block term count and flag an empty block up front.
   always_comb begin
      total_wide          = {4'd0, req_bus.term_total};
      new_item.op         = req_bus.req_type;
      new_item.data       = req_bus.data_byte;
      new_item.total      = (total_wide > 17'(fctm_pkg::MAX_BLOCK_TERMS)) ?
                            fctm_pkg::TERM_TOTAL_W'(fctm_pkg::MAX_BLOCK_TERMS) :
                            req_bus.term_total;
      new_item.total_zero = (req_bus.term_total == '0);
   end

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = q_pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + 2'(push) - 2'(q_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= new_item;
      end
   end

   assign q_valid = (count_ff != 2'd0);
   assign q_item  = entry_ff[rd_ptr_ff];

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= 2'(QDEPTH))
      else $error("queue occupancy beyond its depth");

endmodule

/* hdl/fctm_back.sv */
// Back end: rebuilds front-coded terms, matches them against the query, drives results.
module fctm_back #(
   parameter int MAX_TERM_BYTES = 255
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                q_valid,
   input  fctm_pkg::item_type  q_item,
   output logic                q_pop,
   fctm_rsp_if.source          rsp_bus
);

   localparam int QLW = $clog2(MAX_TERM_BYTES + 1);
   localparam int AW  = $clog2(MAX_TERM_BYTES);
   localparam int TLW = fctm_pkg::TERM_LEN_W;
   localparam int TIW = fctm_pkg::TERM_TOTAL_W;
   localparam int BW  = fctm_pkg::BYTE_W;

   logic [QLW-1:0]                 query_len_ff, query_len_in;
   logic [fctm_pkg::PHASE_W-1:0]   phase_ff, phase_in;
   logic [BW-1:0]                  suffix_left_ff, suffix_left_in;
   logic [TLW-1:0]                 term_len_ff, term_len_in;
   logic [TLW-1:0]                 match_prefix_ff, match_prefix_in;
   logic [TIW-1:0]                 term_index_ff, term_index_in;
   logic [TIW-1:0]                 terms_ff, terms_in;
   logic                           rsp_valid_ff, rsp_valid_in;
   logic                           found_ff, found_in;
   logic [fctm_pkg::INDEX_W-1:0]   index_ff, index_in;

   logic           go, out_free;
   logic           wr_en;
   logic [BW-1:0]  query_byte;
   logic           emit, emit_found;
   logic           fin;
   logic [TLW-1:0] fin_mp, fin_tl, prefix_len, tl_step;
   logic [TIW-1:0] index_next;

   // The query memory is read at the next term length so its data lines up
   // with the current term length when the following byte is processed.
   fctm_ram #(
      .WIDTH (BW),
      .DEPTH (MAX_TERM_BYTES)
   ) u_query_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (query_len_ff[AW-1:0]),
      .wr_data (q_item.data),
      .rd_addr (term_len_in[AW-1:0]),
      .rd_data (query_byte)
   );

   assign out_free = !rsp_valid_ff || rsp_bus.ready;
   assign go       = q_valid && out_free;
   assign q_pop    = go;

   always_comb begin
      query_len_in    = query_len_ff;
      phase_in        = phase_ff;
      suffix_left_in  = suffix_left_ff;
      term_len_in     = term_len_ff;
      match_prefix_in = match_prefix_ff;
      term_index_in   = term_index_ff;
      terms_in        = terms_ff;
      wr_en           = 1'b0;
      emit            = 1'b0;
      emit_found      = 1'b0;
      fin             = 1'b0;
      fin_mp          = match_prefix_ff;
      fin_tl          = term_len_ff;
      prefix_len      = TLW'(q_item.data);
      tl_step         = term_len_ff + 1'b1;
      index_next      = term_index_ff + 1'b1;

      if (go) begin
         case (q_item.op)
            fctm_pkg::OP_CLEAR: begin
               query_len_in = '0;
               phase_in     = fctm_pkg::PH_IDLE;
            end
            fctm_pkg::OP_APPEND: begin
               if (query_len_ff < QLW'(MAX_TERM_BYTES)) begin
                  wr_en        = 1'b1;
                  query_len_in = query_len_ff + 1'b1;
               end
               phase_in = fctm_pkg::PH_IDLE;
            end
            fctm_pkg::OP_START: begin
               terms_in        = q_item.total;
               term_index_in   = '0;
               term_len_in     = '0;
               match_prefix_in = '0;
               suffix_left_in  = '0;
               if (q_item.total_zero) begin
                  emit     = 1'b1;
                  phase_in = fctm_pkg::PH_IDLE;
               end else begin
                  phase_in = fctm_pkg::PH_SUFLEN;
               end
            end
            default: begin
               case (phase_ff)
                  fctm_pkg::PH_PREFIX: begin
                     if (prefix_len > term_len_ff) begin
                        prefix_len = term_len_ff;
                     end
                     if (match_prefix_ff >= prefix_len) begin
                        match_prefix_in = prefix_len;
                     end
                     term_len_in = prefix_len;
                     phase_in    = fctm_pkg::PH_SUFLEN;
                  end
                  fctm_pkg::PH_SUFLEN: begin
                     suffix_left_in = q_item.data;
                     if (q_item.data == '0) begin
                        fin = 1'b1;
                     end else begin
                        phase_in = fctm_pkg::PH_BYTES;
                     end
                  end
                  fctm_pkg::PH_BYTES: begin
                     fin_mp = match_prefix_ff;
                     if (match_prefix_ff == term_len_ff &&
                         term_len_ff < TLW'(query_len_ff) &&
                         query_byte == q_item.data) begin
                        fin_mp = match_prefix_ff + 1'b1;
                     end
                     fin_tl          = tl_step;
                     match_prefix_in = fin_mp;
                     term_len_in     = tl_step;
                     suffix_left_in  = suffix_left_ff - 1'b1;
                     fin             = (suffix_left_ff == BW'(1));
                  end
                  default: begin
                     // A term-area byte with no scan in progress is dropped.
                  end
               endcase
            end
         endcase

         if (fin) begin
            if (fin_mp == fin_tl && fin_tl == TLW'(query_len_ff)) begin
               emit       = 1'b1;
               emit_found = 1'b1;
               phase_in   = fctm_pkg::PH_IDLE;
            end else begin
               term_index_in = index_next;
               if (index_next >= terms_ff) begin
                  emit     = 1'b1;
                  phase_in = fctm_pkg::PH_IDLE;
               end else begin
                  phase_in = fctm_pkg::PH_PREFIX;
               end
            end
         end
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      found_in     = found_ff;
      index_in     = index_ff;
      if (go && emit) begin
         rsp_valid_in = 1'b1;
         found_in     = emit_found;
         index_in     = emit_found ? term_index_ff[fctm_pkg::INDEX_W-1:0] : '0;
      end else if (rsp_bus.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         query_len_ff    <= '0;
         phase_ff        <= fctm_pkg::PH_IDLE;
         suffix_left_ff  <= '0;
         term_len_ff     <= '0;
         match_prefix_ff <= '0;
         term_index_ff   <= '0;
         terms_ff        <= '0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         query_len_ff    <= query_len_in;
         phase_ff        <= phase_in;
         suffix_left_ff  <= suffix_left_in;
         term_len_ff     <= term_len_in;
         match_prefix_ff <= match_prefix_in;
         term_index_ff   <= term_index_in;
         terms_ff        <= terms_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      found_ff <= found_in;
      index_ff <= index_in;
   end

   assign rsp_bus.valid       = rsp_valid_ff;
   assign rsp_bus.found       = found_ff;
   assign rsp_bus.match_index = index_ff;

   a_prefix_within_term: assert property (@(posedge clock) disable iff (reset)
      match_prefix_ff <= term_len_ff)
      else $error("matched prefix longer than the rebuilt term");

   a_index_in_block: assert property (@(posedge clock) disable iff (reset)
      phase_ff != fctm_pkg::PH_IDLE |-> term_index_ff < terms_ff)
      else $error("scan running past the last term of the block");

   a_result_from_item: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(go))
      else $error("result raised without a processed transaction");

endmodule

/* hdl/front_coded_term_matcher_core.sv */
// Top level of the front-coded block term matcher.
// Throughput: one transaction per cycle, sustained, on both channels, while rsp_bus accepts results.
// Results: the transaction that completes a result passes the front queue and then the
// result register before the result is presented on rsp_bus.
// The query memory read is registered and addressed one step ahead by the back end.
// Reset clears the queue, parse state, query length and result valid; query bytes are
// not cleared and are read only after being written.
module front_coded_term_matcher_core #(
   parameter int MAX_TERM_BYTES = 255
) (
   input  logic        clock,
   input  logic        reset,
   fctm_req_if.sink    req_bus,
   fctm_rsp_if.source  rsp_bus
);

   logic               q_valid;
   logic               q_pop;
   fctm_pkg::item_type q_item;

   fctm_front u_front (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .q_valid (q_valid),
      .q_item  (q_item),
      .q_pop   (q_pop)
   );

   fctm_back #(
      .MAX_TERM_BYTES (MAX_TERM_BYTES)
   ) u_back (
      .clock   (clock),
      .reset   (reset),
      .q_valid (q_valid),
      .q_item  (q_item),
      .q_pop   (q_pop),
      .rsp_bus (rsp_bus)
   );

endmodule

/* tb/sv/tb_top.sv */
// Self-checking testbench for the front-coded term matcher core.
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import fctm_pkg::*;

   localparam int QUERY_CAP      = 255;
   localparam int CYCLE_LIMIT    = 400000;
   localparam int RANDOM_ITEMS   = 150;
   localparam int RANDOM_ANSWERS = 24;

   typedef logic [BYTE_W-1:0] text_type[$];

   typedef struct packed {
      logic               found;
      logic [INDEX_W-1:0] index;
   } lookup_type;

   logic clock = 1'b0;
   logic reset;

   fctm_req_if req_bus();
   fctm_rsp_if rsp_bus();

   front_coded_term_matcher_core DUT (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Expected behavior of the matcher.
   logic [BYTE_W-1:0]     query_mem [QUERY_CAP];
   int unsigned           query_count;
   logic [PHASE_W-1:0]    scan_phase;
   int unsigned           bytes_to_go;
   logic [TERM_LEN_W-1:0] built_len;
   logic [TERM_LEN_W-1:0] agree_len;
   int unsigned           term_pos;
   int unsigned           block_terms;

   lookup_type  lookups_due[$];
   int unsigned lookups_predicted = 0;
   int unsigned live_items = 0;
   int          error_count = 0;
   int unsigned cycle_count = 0;
   int unsigned rsp_hold = 0;
   bit          steady = 1'b0;

   task automatic report_mismatch(input string what, input int unsigned want,
                                  input int unsigned got);
      $display("MISMATCH cycle %0d: %s expected %0d got %0d", cycle_count, what, want, got);
      error_count++;
   endtask

   function automatic void close_term();
      lookup_type answer;
      if (agree_len == built_len && built_len == query_count) begin
         answer.found = 1'b1;
         answer.index = term_pos[INDEX_W-1:0];
      end else begin
         term_pos++;
         if (term_pos < block_terms) begin
            scan_phase = PH_PREFIX;
            return;
         end
         answer = '0;
      end
      scan_phase = PH_IDLE;
      lookups_due.push_back(answer);
      lookups_predicted++;
   endfunction

   function automatic void predict_lookup(input logic [REQ_TYPE_W-1:0] op,
                                          input logic [BYTE_W-1:0] data,
                                          input logic [TERM_TOTAL_W-1:0] total);
      int unsigned           count;
      logic [TERM_LEN_W-1:0] shared_len;
      if (!(op == OP_BYTE && scan_phase == PH_IDLE))
         live_items++;
      case (op)
         OP_CLEAR: begin
            query_count = 0;
            scan_phase  = PH_IDLE;
         end
         OP_APPEND: begin
            if (query_count < QUERY_CAP) begin
               query_mem[query_count] = data;
               query_count++;
            end
            scan_phase = PH_IDLE;
         end
         OP_START: begin
            count       = (total > MAX_BLOCK_TERMS) ? MAX_BLOCK_TERMS : total;
            block_terms = count;
            term_pos    = 0;
            built_len   = '0;
            agree_len   = '0;
            bytes_to_go = 0;
            if (count == 0) begin
               scan_phase = PH_IDLE;
               lookups_due.push_back('0);
               lookups_predicted++;
            end else begin
               scan_phase = PH_SUFLEN;
            end
         end
         default: begin
            case (scan_phase)
               PH_PREFIX: begin
                  shared_len = (data > built_len) ? built_len : TERM_LEN_W'(data);
                  if (agree_len >= shared_len)
                     agree_len = shared_len;
                  built_len  = shared_len;
                  scan_phase = PH_SUFLEN;
               end
               PH_SUFLEN: begin
                  bytes_to_go = data;
                  if (data == 0)
                     close_term();
                  else
                     scan_phase = PH_BYTES;
               end
               PH_BYTES: begin
                  if (agree_len == built_len && built_len < query_count &&
                      query_mem[built_len] == data)
                     agree_len++;
                  built_len++;
                  bytes_to_go--;
                  if (bytes_to_go == 0)
                     close_term();
               end
               default: ;
            endcase
         end
      endcase
   endfunction

   // Both handshakes are sampled here, requests before results.
   always @(posedge clock) begin : watch_bus
      lookup_type want;
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("front_coded_term_matcher_core verification failed");
         $finish;
      end else if (!reset) begin
         if (req_bus.valid && req_bus.ready)
            predict_lookup(req_bus.req_type, req_bus.data_byte, req_bus.term_total);
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (lookups_due.size() == 0) begin
               report_mismatch("result with none pending, found", 0, rsp_bus.found);
            end else begin
               want = lookups_due.pop_front();
               if (rsp_bus.found !== want.found)
                  report_mismatch("found", want.found, rsp_bus.found);
               if (rsp_bus.match_index !== want.index)
                  report_mismatch("match_index", want.index, rsp_bus.match_index);
            end
            rsp_hold = steady ? 0 : $urandom_range(0, 6);
         end
      end
   end

   always @(negedge clock) begin
      if (rsp_hold > 0) begin
         rsp_bus.ready <= 1'b0;
         rsp_hold--;
      end else begin
         rsp_bus.ready <= 1'b1;
      end
   end

   task automatic send_item(input logic [REQ_TYPE_W-1:0] op,
                            input logic [BYTE_W-1:0] data = '0,
                            input logic [TERM_TOTAL_W-1:0] total = '0);
      int unsigned gap;
      gap = steady ? 0 : $urandom_range(0, 6);
      repeat (gap) begin
         @(negedge clock);
         req_bus.valid <= 1'b0;
      end
      @(negedge clock);
      req_bus.valid      <= 1'b1;
      req_bus.req_type   <= op;
      req_bus.data_byte  <= data;
      req_bus.term_total <= total;
      do @(posedge clock); while (!req_bus.ready);
   endtask

   task automatic load_query(input text_type text);
      send_item(OP_CLEAR);
      foreach (text[i])
         send_item(OP_APPEND, text[i]);
   endtask

   // The first term of a block carries no shared-prefix length.
   task automatic send_term(input bit first, input logic [BYTE_W-1:0] shared,
                            input text_type suffix);
      if (!first)
         send_item(OP_BYTE, shared);
      send_item(OP_BYTE, BYTE_W'(suffix.size()));
      foreach (suffix[i])
         send_item(OP_BYTE, suffix[i]);
   endtask

   function automatic text_type random_text(input int unsigned len);
      text_type text;
      repeat (len)
         text.push_back(BYTE_W'($urandom_range(0, 255)));
      return text;
   endfunction

   task automatic test_basic_match();
      load_query({8'h61, 8'h62});
      send_item(OP_START, 8'h00, 13'd3);
      send_term(1'b1, 8'd0, {8'h61});
      send_term(1'b0, 8'd1, {8'h62});
   endtask

   task automatic test_special_cases();
      text_type none;
      send_item(OP_BYTE, 8'hFF);
      send_item(OP_START, 8'h00, 13'd0);
      // A zero byte is an ordinary query byte; the shared prefix of 200 saturates to zero.
      load_query({8'h00});
      send_item(OP_START, 8'h00, 13'd3);
      send_term(1'b1, 8'd0, none);
      send_term(1'b0, 8'd200, {8'h00});
      // A new start drops the scan in progress.
      send_item(OP_START, 8'h00, 13'd5);
      send_item(OP_BYTE, 8'd2);
      send_item(OP_BYTE, 8'h00);
      send_item(OP_START, 8'h00, 13'd1);
      send_term(1'b1, 8'd0, none);
      // Touching the query aborts the scan without a result.
      send_item(OP_START, 8'h00, 13'd2);
      send_item(OP_BYTE, 8'd1);
      send_item(OP_APPEND, 8'hFF);
      send_item(OP_CLEAR);
      send_item(OP_START, 8'h00, 13'h1FFF);
      send_term(1'b1, 8'd0, none);
      send_item(OP_APPEND, 8'hAA);
      send_item(OP_START, 8'h00, 13'd1);
      send_term(1'b1, 8'd0, {8'h55});
   endtask

   task automatic test_long_query();
      text_type text;
      text_type head;
      text = random_text(QUERY_CAP + 1);
      load_query(text);
      for (int i = 0; i < QUERY_CAP - 1; i++)
         head.push_back(text[i]);
      send_item(OP_START, 8'h00, 13'd2);
      send_term(1'b1, 8'd0, head);
      send_term(1'b0, BYTE_W'(QUERY_CAP - 1), {text[QUERY_CAP-1]});
   endtask

   // Oversized term counts still run the scan and report early matches.
   task automatic test_count_saturation();
      text_type none;
      load_query({8'h01});
      send_item(OP_START, 8'h00, 13'd4097);
      send_term(1'b1, 8'd0, none);
      send_term(1'b0, 8'd0, {8'h01});
      send_item(OP_START, 8'h00, 13'h1FFF);
      send_term(1'b1, 8'd0, {8'h01});
   endtask

   task automatic test_random_lookups();
      text_type    query_text;
      text_type    prev_text;
      text_type    term_text;
      text_type    suffix;
      int unsigned answers_before;
      int unsigned n_terms;
      int unsigned hit_pos;
      int unsigned shared;
      int unsigned shared_field;
      int unsigned cut;
      bit          broken;
      bit          query_stale;
      answers_before = lookups_predicted;
      live_items     = 0;
      query_stale    = 1'b1;
      while (live_items < RANDOM_ITEMS ||
             lookups_predicted - answers_before < RANDOM_ANSWERS) begin
         steady = ($urandom_range(0, 7) == 0);
         if ($urandom_range(0, 9) == 0) begin
            repeat ($urandom_range(1, 4))
               send_item(REQ_TYPE_W'($urandom_range(0, 3)), BYTE_W'($urandom_range(0, 255)),
                         TERM_TOTAL_W'(($urandom_range(0, 3) == 0) ? $urandom_range(0, 8191)
                                                                   : $urandom_range(0, 8)));
            query_stale = 1'b1;
            continue;
         end
         if (query_stale || $urandom_range(0, 2) != 0) begin
            query_text = random_text(($urandom_range(0, 19) == 0) ? $urandom_range(0, 60)
                                                                 : $urandom_range(0, 8));
            load_query(query_text);
            query_stale = 1'b0;
         end
         n_terms = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 20) : $urandom_range(1, 6);
         hit_pos = $urandom_range(0, 2 * n_terms - 1);
         broken  = ($urandom_range(0, 9) == 0);
         cut     = $urandom_range(0, n_terms - 1);
         send_item(OP_START, BYTE_W'($urandom_range(0, 255)),
                   TERM_TOTAL_W'(broken ? n_terms + $urandom_range(0, 3) : n_terms));
         prev_text.delete();
         for (int i = 0; i < n_terms; i++) begin
            if (i == hit_pos) begin
               term_text = query_text;
            end else begin
               case ($urandom_range(0, 4))
                  0: begin
                     term_text = query_text;
                     repeat ($urandom_range(1, 3))
                        if (term_text.size() > 0)
                           void'(term_text.pop_back());
                  end
                  1: begin
                     term_text = query_text;
                     term_text.push_back(BYTE_W'($urandom_range(0, 255)));
                  end
                  2: begin
                     term_text = query_text;
                     if (term_text.size() > 0) begin
                        int unsigned k;
                        k = $urandom_range(0, term_text.size() - 1);
                        term_text[k] = term_text[k] ^ BYTE_W'($urandom_range(1, 255));
                     end
                  end
                  3: term_text = random_text($urandom_range(0, 6));
                  default: begin
                     term_text = prev_text;
                     repeat ($urandom_range(0, 3))
                        if (term_text.size() > 0)
                           void'(term_text.pop_back());
                     term_text = {term_text, random_text($urandom_range(1, 3))};
                  end
               endcase
            end
            while (term_text.size() > QUERY_CAP)
               void'(term_text.pop_back());
            shared = 0;
            if (i != 0)
               while (shared < prev_text.size() && shared < term_text.size() &&
                      prev_text[shared] == term_text[shared])
                  shared++;
            shared_field = shared;
            if (i != 0) begin
               case ($urandom_range(0, 9))
                  0: begin
                     shared       = $urandom_range(0, shared);
                     shared_field = shared;
                  end
                  // Claims more than the previous term holds; only legal when it is a prefix.
                  1: if (shared == prev_text.size()) begin
                     shared_field = shared + $urandom_range(1, 40);
                     if (shared_field > 255)
                        shared_field = 255;
                  end
                  default: ;
               endcase
            end
            suffix.delete();
            for (int k = shared; k < term_text.size(); k++)
               suffix.push_back(term_text[k]);
            if (broken && i == cut) begin
               if (i != 0)
                  send_item(OP_BYTE, BYTE_W'(shared_field));
               if (suffix.size() > 1) begin
                  send_item(OP_BYTE, BYTE_W'(suffix.size()));
                  send_item(OP_BYTE, suffix[0]);
               end
               break;
            end
            send_term(i == 0, BYTE_W'(shared_field), suffix);
            prev_text = term_text;
         end
      end
      steady = 1'b0;
   endtask

   initial begin
      reset                = 1'b1;
      req_bus.valid        = 1'b0;
      req_bus.req_type     = OP_CLEAR;
      req_bus.data_byte    = '0;
      req_bus.term_total   = '0;
      rsp_bus.ready        = 1'b0;
      query_count          = 0;
      scan_phase           = PH_IDLE;
      bytes_to_go          = 0;
      built_len            = '0;
      agree_len            = '0;
      term_pos             = 0;
      block_terms          = 0;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_basic_match();
      test_special_cases();
      test_long_query();
      test_count_saturation();
      test_random_lookups();

      @(negedge clock);
      req_bus.valid <= 1'b0;
      while (lookups_due.size() != 0)
         @(posedge clock);
      repeat (20) @(posedge clock);
      if (error_count == 0)
         $display("front_coded_term_matcher_core verification clean");
      else
         $display("front_coded_term_matcher_core verification failed");
      $finish;
   end

endmodule
